/* src/mfb_pkg.sv */
// ----------------------------------------------------------------------------
// mfb_pkg
// Shared types and constants for the monochrome frame buffer draw/scroll block.
// ----------------------------------------------------------------------------
package mfb_pkg;

    localparam int DEF_CANVAS_WIDTH  = 128;
    localparam int DEF_CANVAS_HEIGHT = 32;

    // Widest row index and widest column arithmetic (x + w + 1)
    localparam int ROW_IDX_W = 6;
    localparam int X_W       = 9;

    typedef enum logic [2:0] {
        FN_CLEAR = 3'd0,
        FN_LINE  = 3'd1,
        FN_RECT  = 3'd2,
        FN_SHR   = 3'd3,
        FN_SHD   = 3'd4,
        FN_READ  = 3'd5
    } t_func;

    typedef enum logic [1:0] {
        ALU_OR,
        ALU_SHIFT,
        ALU_COPY
    } t_alu_op;

    typedef struct packed {
        t_alu_op        op;
        logic [X_W-1:0] x_lo;
        logic [X_W-1:0] x_hi;
        logic           edges_only;
        logic [X_W-1:0] x_a;
        logic [X_W-1:0] x_b;
    } t_alu_ctl;

    typedef struct packed {
        logic                 clear;
        logic                 rd_en;
        logic [ROW_IDX_W-1:0] rd_row;
        logic                 wr_en;
        logic [ROW_IDX_W-1:0] wr_row;
    } t_store_req;

endpackage

/* src/mfb_row_store.sv */
// ----------------------------------------------------------------------------
// mfb_row_store
// Row-wide pixel memory with per-row valid bits; an invalid row reads as zero.
// ----------------------------------------------------------------------------
module mfb_row_store #(
    parameter int CANVAS_WIDTH  = mfb_pkg::DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = mfb_pkg::DEF_CANVAS_HEIGHT
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  mfb_pkg::t_store_req     i_req,
    input  logic [CANVAS_WIDTH-1:0] i_wr_data,
    output logic [CANVAS_WIDTH-1:0] o_rd_data
);

    localparam int ROW_W = $clog2(CANVAS_HEIGHT);

    logic [CANVAS_WIDTH-1:0]  r_mem [CANVAS_HEIGHT];
    logic [CANVAS_HEIGHT-1:0] r_valid;
    logic [CANVAS_WIDTH-1:0]  r_rd_data;
    logic                     r_rd_ok;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_row[ROW_W-1:0]] <= i_wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_row[ROW_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_ok <= 1'b0;
        end else begin
            if (i_req.clear) begin
                r_valid <= '0;
            end else if (i_req.wr_en) begin
                r_valid[i_req.wr_row[ROW_W-1:0]] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_ok <= r_valid[i_req.rd_row[ROW_W-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_ok ? r_rd_data : '0;

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.clear |=> (r_valid == '0))
        else $error("row valid bits not cleared");

endmodule

/* src/mfb_row_alu.sv */
// ----------------------------------------------------------------------------
// mfb_row_alu
// Shared row unit: OR a column span or edge mask, shift by one column, or copy.
// ----------------------------------------------------------------------------
module mfb_row_alu #(
    parameter int CANVAS_WIDTH = mfb_pkg::DEF_CANVAS_WIDTH
) (
    input  mfb_pkg::t_alu_ctl       i_ctl,
    input  logic [CANVAS_WIDTH-1:0] i_data,
    output logic [CANVAS_WIDTH-1:0] o_data
);

    logic [CANVAS_WIDTH-1:0] mask;

    always_comb begin
        for (int c = 0; c < CANVAS_WIDTH; c++) begin
            if (i_ctl.edges_only) begin
                mask[c] = (mfb_pkg::X_W'(c) == i_ctl.x_a) || (mfb_pkg::X_W'(c) == i_ctl.x_b);
            end else begin
                mask[c] = (mfb_pkg::X_W'(c) >= i_ctl.x_lo) && (mfb_pkg::X_W'(c) < i_ctl.x_hi);
            end
        end
    end

    always_comb begin
        case (i_ctl.op)
            mfb_pkg::ALU_OR:    o_data = i_data | mask;
            mfb_pkg::ALU_SHIFT: o_data = {i_data[CANVAS_WIDTH-2:0], 1'b0};
            default:            o_data = i_data;
        endcase
    end

endmodule

/* src/mono_framebuffer_draw_scroll.sv */
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_scroll
// One-bit frame buffer: clear, line, rectangle, shift right/down, pixel read.
// ----------------------------------------------------------------------------
// Each command returns one result (pixel_value, command_done). The picture is
// kept one canvas row per memory word, and a small sequencer runs every row a
// command touches through one shared row unit: a registered row read, then a
// row write for each row. Clear, unknown commands and commands with no row to
// walk (nothing drawn, start row below the canvas, a read outside the canvas)
// give their result without a row pass; a pixel read inside the canvas walks
// one row; a line or rectangle walks the rows it spans inside the canvas, even
// when all of its columns fall outside; a shift walks every row. Input stalls
// while a command is in progress and while an earlier result is still
// stalled. The store reads all zero right after reset, with no clearing pass.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_scroll #(
    parameter int CANVAS_WIDTH  = mfb_pkg::DEF_CANVAS_WIDTH,
    parameter int CANVAS_HEIGHT = mfb_pkg::DEF_CANVAS_HEIGHT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [2:0] i_func,
    input  logic [7:0] i_pos_x,
    input  logic [5:0] i_pos_y,
    input  logic [7:0] i_end_x,
    input  logic [5:0] i_end_y,
    input  logic [7:0] i_rect_width,
    input  logic [5:0] i_rect_height,
    input  logic       i_fill,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_pixel_value,
    output logic       o_command_done
);

    localparam int ROW_W = $clog2(CANVAS_HEIGHT);
    localparam int COL_W = $clog2(CANVAS_WIDTH);
    localparam int XW    = mfb_pkg::X_W;
    localparam logic [6:0]       LAST_ROW7 = 7'(CANVAS_HEIGHT - 1);
    localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(CANVAS_HEIGHT - 1);

    typedef enum logic [1:0] {S_IDLE, S_RD, S_WR} t_state;
    typedef enum logic [1:0] {OP_DRAW, OP_SHR, OP_SHD, OP_READ} t_op;

    t_state           r_state;
    t_op              r_op;
    logic [ROW_W-1:0] r_row;
    logic [ROW_W-1:0] r_row_lo;
    logic [COL_W-1:0] r_px;
    logic [6:0]       r_top;
    logic [6:0]       r_bot;
    logic             r_outline;
    logic [XW-1:0]    r_x_lo;
    logic [XW-1:0]    r_x_hi;
    logic [XW-1:0]    r_x_a;
    logic [XW-1:0]    r_x_b;
    logic             r_out_valid;
    logic             r_out_pix;

    logic             in_xfer;
    t_op              d_op;
    logic             d_ok;
    logic             d_go;
    logic [6:0]       d_ylo;
    logic [6:0]       d_yhi;
    logic [6:0]       d_yhi_c;
    logic [XW-1:0]    d_x_lo;
    logic [XW-1:0]    d_x_hi;
    logic             d_outline;

    logic [6:0]       py7;
    logic [6:0]       ey7;
    logic [6:0]       rh7;
    logic [XW-1:0]    px9;
    logic [XW-1:0]    ex9;
    logic [XW-1:0]    rw9;

    mfb_pkg::t_store_req     store_req;
    mfb_pkg::t_alu_ctl       alu_ctl;
    logic [CANVAS_WIDTH-1:0] rd_data;
    logic [CANVAS_WIDTH-1:0] alu_in;
    logic [CANVAS_WIDTH-1:0] wr_data;
    logic                    last_row;

    assign o_in_stall = (r_state != S_IDLE) || (r_out_valid && i_out_stall);
    assign in_xfer    = i_in_valid && !o_in_stall;

    assign py7 = 7'(i_pos_y);
    assign ey7 = 7'(i_end_y);
    assign rh7 = 7'(i_rect_height);
    assign px9 = XW'(i_pos_x);
    assign ex9 = XW'(i_end_x);
    assign rw9 = XW'(i_rect_width);

    // Command decode: row span, column span, and whether rows must be walked
    always_comb begin
        d_op      = OP_DRAW;
        d_ok      = 1'b0;
        d_ylo     = py7;
        d_yhi     = py7;
        d_x_lo    = px9;
        d_x_hi    = px9;
        d_outline = 1'b0;
        unique case (mfb_pkg::t_func'(i_func))
            mfb_pkg::FN_LINE: begin
                if (i_pos_y == i_end_y) begin
                    d_ok   = ex9 > px9;
                    d_x_hi = ex9;
                end else if (i_pos_x == i_end_x) begin
                    d_ok   = ey7 > py7;
                    d_yhi  = ey7 - 7'd1;
                    d_x_hi = px9 + 9'd1;
                end
            end
            mfb_pkg::FN_RECT: begin
                if (i_fill) begin
                    d_ok   = (i_rect_height != '0) && (i_rect_width != '0);
                    d_yhi  = py7 + rh7 - 7'd1;
                    d_x_hi = px9 + rw9;
                end else begin
                    d_ok      = 1'b1;
                    d_yhi     = py7 + rh7;
                    d_x_hi    = px9 + rw9 + 9'd1;
                    d_outline = 1'b1;
                end
            end
            mfb_pkg::FN_SHR: begin
                d_op  = OP_SHR;
                d_ok  = 1'b1;
                d_ylo = '0;
                d_yhi = LAST_ROW7;
            end
            mfb_pkg::FN_SHD: begin
                d_op  = OP_SHD;
                d_ok  = 1'b1;
                d_ylo = '0;
                d_yhi = LAST_ROW7;
            end
            mfb_pkg::FN_READ: begin
                d_op = OP_READ;
                d_ok = (px9 < XW'(CANVAS_WIDTH));
            end
            default: begin
                d_ok = 1'b0;
            end
        endcase
        d_go    = d_ok && (d_ylo <= LAST_ROW7);
        d_yhi_c = (d_yhi > LAST_ROW7) ? LAST_ROW7 : d_yhi;
    end

    assign last_row = (r_row == r_row_lo);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_op        <= OP_DRAW;
            r_out_valid <= 1'b0;
            r_out_pix   <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op      <= d_op;
                        r_row     <= d_yhi_c[ROW_W-1:0];
                        r_row_lo  <= d_ylo[ROW_W-1:0];
                        r_px      <= i_pos_x[COL_W-1:0];
                        r_top     <= py7;
                        r_bot     <= d_yhi;
                        r_outline <= d_outline;
                        r_x_lo    <= d_x_lo;
                        r_x_hi    <= d_x_hi;
                        r_x_a     <= px9;
                        r_x_b     <= px9 + rw9;
                        if (d_go) begin
                            r_state <= S_RD;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_pix   <= 1'b0;
                        end
                    end
                end
                S_RD: begin
                    r_state <= S_WR;
                end
                S_WR: begin
                    if (last_row) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_out_pix   <= (r_op == OP_READ) ? rd_data[r_px] : 1'b0;
                    end else begin
                        r_row   <= r_row - 1'b1;
                        r_state <= S_RD;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        store_req.clear  = in_xfer && (mfb_pkg::t_func'(i_func) == mfb_pkg::FN_CLEAR);
        store_req.rd_en  = (r_state == S_RD);
        store_req.rd_row = (r_op == OP_SHD) ? mfb_pkg::ROW_IDX_W'(r_row - 1'b1)
                                            : mfb_pkg::ROW_IDX_W'(r_row);
        store_req.wr_en  = (r_state == S_WR) && (r_op != OP_READ);
        store_req.wr_row = mfb_pkg::ROW_IDX_W'(r_row);
    end

    always_comb begin
        case (r_op)
            OP_SHR:  alu_ctl.op = mfb_pkg::ALU_SHIFT;
            OP_DRAW: alu_ctl.op = mfb_pkg::ALU_OR;
            default: alu_ctl.op = mfb_pkg::ALU_COPY;
        endcase
        alu_ctl.x_lo       = r_x_lo;
        alu_ctl.x_hi       = r_x_hi;
        alu_ctl.x_a        = r_x_a;
        alu_ctl.x_b        = r_x_b;
        alu_ctl.edges_only = r_outline && (7'(r_row) != r_top) && (7'(r_row) != r_bot);
    end

    // Top row of a downward shift takes zeros
    assign alu_in = ((r_op == OP_SHD) && (r_row == '0)) ? '0 : rd_data;

    mfb_row_store #(
        .CANVAS_WIDTH  (CANVAS_WIDTH),
        .CANVAS_HEIGHT (CANVAS_HEIGHT)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (store_req),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

    mfb_row_alu #(
        .CANVAS_WIDTH (CANVAS_WIDTH)
    ) u_alu (
        .i_ctl  (alu_ctl),
        .i_data (alu_in),
        .o_data (wr_data)
    );

    assign o_out_valid    = r_out_valid;
    assign o_pixel_value  = r_out_pix;
    assign o_command_done = r_out_valid;

    a_row_in_canvas: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_row <= LAST_ROW))
        else $error("row counter beyond canvas");

    a_rd_then_wr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RD) |=> (r_state == S_WR))
        else $error("row read not followed by row write");

    a_last_row_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WR && last_row) |=> (r_state == S_IDLE && r_out_valid))
        else $error("command end without result");

    a_pixel_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_pix) |-> (r_op == OP_READ))
        else $error("pixel value set on a non-read command");

endmodule

/* tb/tb_mono_framebuffer_draw_scroll.sv */
// ----------------------------------------------------------------------------
// tb_mono_framebuffer_draw_scroll
// Command-level check of the one-bit frame buffer against a local pixel model.
// ----------------------------------------------------------------------------
// Directed commands cover line and rectangle corner cases, clipping, shifts,
// reads outside the canvas and spare function codes. Random command streams
// then run with bursty input and a stalling output, including one long output
// hold-off. Each reply is compared with the model's prediction in order.
// ----------------------------------------------------------------------------
module tb_mono_framebuffer_draw_scroll;

    localparam int CANVAS_W     = mfb_pkg::DEF_CANVAS_WIDTH;
    localparam int CANVAS_H     = mfb_pkg::DEF_CANVAS_HEIGHT;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 100;
    localparam int HOLD_CYCLES  = 300;

    localparam logic [2:0] FN_SPARE_6 = 3'd6;
    localparam logic [2:0] FN_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [2:0] func;
        logic [7:0] pos_x;
        logic [5:0] pos_y;
        logic [7:0] end_x;
        logic [5:0] end_y;
        logic [7:0] rect_w;
        logic [5:0] rect_h;
        logic       fill;
    } t_draw_cmd;

    typedef struct packed {
        logic pixel;
        logic done;
    } t_reply;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_in_valid    = 1'b0;
    logic [2:0] i_func        = '0;
    logic [7:0] i_pos_x       = '0;
    logic [5:0] i_pos_y       = '0;
    logic [7:0] i_end_x       = '0;
    logic [5:0] i_end_y       = '0;
    logic [7:0] i_rect_width  = '0;
    logic [5:0] i_rect_height = '0;
    logic       i_fill        = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_pixel_value;
    logic       o_command_done;

    logic [CANVAS_W-1:0] picture [CANVAS_H];
    t_reply              pending_replies [$];
    int                  mismatch_count = 0;
    int                  reply_index    = 0;
    int                  cycle_count    = 0;

    int unsigned tx_gap_max    = 0;
    int unsigned tx_burst_max  = 1;
    int unsigned tx_burst_left = 0;
    int unsigned rx_stall_pct  = 0;
    int unsigned rx_run_left   = 0;
    bit          rx_run_stalled = 1'b0;
    int          hold_requested = 0;
    int          hold_served    = 0;
    int          hold_left      = 0;

    logic [7:0] last_x = '0;
    logic [5:0] last_y = '0;

    mono_framebuffer_draw_scroll dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_func         (i_func),
        .i_pos_x        (i_pos_x),
        .i_pos_y        (i_pos_y),
        .i_end_x        (i_end_x),
        .i_end_y        (i_end_y),
        .i_rect_width   (i_rect_width),
        .i_rect_height  (i_rect_height),
        .i_fill         (i_fill),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_pixel_value  (o_pixel_value),
        .o_command_done (o_command_done)
    );

    always #1 i_clk = ~i_clk;

    // ---------------- pixel model ----------------

    function automatic void set_pixel(int x, int y);
        if (x < CANVAS_W && y < CANVAS_H) begin
            picture[y][x] = 1'b1;
        end
    endfunction

    function automatic t_reply apply_command(t_draw_cmd req);
        t_reply r;
        int x, y, ex, ey, w, h;
        r.pixel = 1'b0;
        r.done  = 1'b1;
        x  = req.pos_x;
        y  = req.pos_y;
        ex = req.end_x;
        ey = req.end_y;
        w  = req.rect_w;
        h  = req.rect_h;
        case (req.func)
            mfb_pkg::FN_CLEAR: begin
                foreach (picture[row]) picture[row] = '0;
            end
            mfb_pkg::FN_LINE: begin
                if (y == ey) begin
                    for (int k = x; k < ex; k++) set_pixel(k, y);
                end else if (x == ex) begin
                    for (int k = y; k < ey; k++) set_pixel(x, k);
                end
            end
            mfb_pkg::FN_RECT: begin
                if (req.fill) begin
                    for (int row = y; row < y + h; row++)
                        for (int col = x; col < x + w; col++) set_pixel(col, row);
                end else begin
                    for (int col = x; col <= x + w; col++) begin
                        set_pixel(col, y);
                        set_pixel(col, y + h);
                    end
                    for (int row = y; row <= y + h; row++) begin
                        set_pixel(x, row);
                        set_pixel(x + w, row);
                    end
                end
            end
            mfb_pkg::FN_SHR: begin
                foreach (picture[row]) picture[row] = picture[row] << 1;
            end
            mfb_pkg::FN_SHD: begin
                for (int row = CANVAS_H - 1; row > 0; row--) picture[row] = picture[row - 1];
                picture[0] = '0;
            end
            mfb_pkg::FN_READ: begin
                if (x < CANVAS_W && y < CANVAS_H) r.pixel = picture[y][x];
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------- stimulus ----------------

    function automatic t_draw_cmd make_cmd(logic [2:0] func, int px, int py, int ex, int ey,
                                           int w, int h, bit f);
        t_draw_cmd req;
        req.func   = func;
        req.pos_x  = 8'(px);
        req.pos_y  = 6'(py);
        req.end_x  = 8'(ex);
        req.end_y  = 6'(ey);
        req.rect_w = 8'(w);
        req.rect_h = 6'(h);
        req.fill   = f;
        return req;
    endfunction

    function automatic t_draw_cmd random_command();
        t_draw_cmd   req;
        int unsigned pick;
        bit          wide;
        pick = $urandom_range(99);
        wide = ($urandom_range(7) == 0);
        req.func   = 3'($urandom);
        req.pos_x  = 8'($urandom);
        req.pos_y  = 6'($urandom);
        req.end_x  = 8'($urandom);
        req.end_y  = 6'($urandom);
        req.rect_w = 8'($urandom);
        req.rect_h = 6'($urandom);
        req.fill   = 1'($urandom);
        if (pick < 3) begin
            req.func = mfb_pkg::FN_CLEAR;
        end else if (pick < 32) begin
            req.func = mfb_pkg::FN_LINE;
            if (!wide) begin
                req.pos_x = 8'($urandom_range(CANVAS_W + 7));
                req.pos_y = 6'($urandom_range(CANVAS_H + 3));
                if ($urandom_range(1)) begin
                    req.end_y = req.pos_y;
                    req.end_x = req.pos_x + 8'($urandom_range(48));
                end else begin
                    req.end_x = req.pos_x;
                    req.end_y = req.pos_y + 6'($urandom_range(12));
                end
            end
            last_x = req.pos_x;
            last_y = req.pos_y;
        end else if (pick < 60) begin
            req.func = mfb_pkg::FN_RECT;
            if (!wide) begin
                req.pos_x  = 8'($urandom_range(CANVAS_W + 7));
                req.pos_y  = 6'($urandom_range(CANVAS_H + 3));
                req.rect_w = 8'($urandom_range(40));
                req.rect_h = 6'($urandom_range(10));
            end
            last_x = req.pos_x;
            last_y = req.pos_y;
        end else if (pick < 65) begin
            req.func = mfb_pkg::FN_SHR;
        end else if (pick < 70) begin
            req.func = mfb_pkg::FN_SHD;
        end else if (pick < 95) begin
            req.func = mfb_pkg::FN_READ;
            if (!wide) begin
                if ($urandom_range(1)) begin
                    req.pos_x = last_x + 8'($urandom_range(3));
                    req.pos_y = last_y + 6'($urandom_range(3));
                end else begin
                    req.pos_x = 8'($urandom_range(CANVAS_W + 7));
                    req.pos_y = 6'($urandom_range(CANVAS_H + 3));
                end
            end
        end else begin
            req.func = $urandom_range(1) ? FN_SPARE_6 : FN_SPARE_7;
        end
        return req;
    endfunction

    // Call at a rising edge; returns at the edge where the transfer happened,
    // leaving valid high.
    task automatic send_command(t_draw_cmd req);
        int unsigned gap;
        if (tx_burst_left == 0) begin
            tx_burst_left = $urandom_range(1, tx_burst_max);
            gap = (tx_gap_max == 0) ? 0 : $urandom_range(0, tx_gap_max);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        tx_burst_left--;
        i_func        <= req.func;
        i_pos_x       <= req.pos_x;
        i_pos_y       <= req.pos_y;
        i_end_x       <= req.end_x;
        i_end_y       <= req.end_y;
        i_rect_width  <= req.rect_w;
        i_rect_height <= req.rect_h;
        i_fill        <= req.fill;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        pending_replies.push_back(apply_command(req));
    endtask

    // ---------------- tests ----------------

    task automatic test_reset_state();
        send_command(make_cmd(mfb_pkg::FN_READ, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, CANVAS_W - 1, CANVAS_H - 1, 0, 0, 0, 0, 0));
    endtask

    task automatic test_lines();
        send_command(make_cmd(mfb_pkg::FN_LINE, 120, 5, 255, 5, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, CANVAS_W - 1, 5, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_LINE, 3, 28, 3, 63, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 3, CANVAS_H - 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_LINE, 10, 10, 20, 20, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 10, 10, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_LINE, 50, 7, 40, 7, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 45, 7, 0, 0, 0, 0, 0));
    endtask

    task automatic test_rectangles();
        send_command(make_cmd(mfb_pkg::FN_RECT, 20, 12, 0, 0, 10, 5, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 30, 17, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 25, 14, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_RECT, 60, 20, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 60, 20, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_RECT, 0, 0, 0, 0, 0, 4, 1));
        send_command(make_cmd(mfb_pkg::FN_RECT, 250, 60, 0, 0, 255, 63, 0));
        send_command(make_cmd(mfb_pkg::FN_RECT, 100, 25, 0, 0, 255, 63, 1));
        send_command(make_cmd(mfb_pkg::FN_READ, 255, 63, 0, 0, 0, 0, 0));
    endtask

    task automatic test_shifts();
        send_command(make_cmd(mfb_pkg::FN_SHR, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, 4, CANVAS_H - 1, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_SHD, 0, 0, 0, 0, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_READ, CANVAS_W - 1, 6, 0, 0, 0, 0, 0));
    endtask

    task automatic test_spare_codes_and_clear();
        send_command(make_cmd(FN_SPARE_6, 255, 63, 255, 63, 255, 63, 1));
        send_command(make_cmd(FN_SPARE_7, 4, 31, 4, 31, 0, 0, 0));
        send_command(make_cmd(mfb_pkg::FN_CLEAR, 255, 63, 255, 63, 255, 63, 1));
        send_command(make_cmd(mfb_pkg::FN_READ, CANVAS_W - 1, 6, 0, 0, 0, 0, 0));
    endtask

    task automatic test_random_mix();
        tx_gap_max   = 0;
        tx_burst_max = 8;
        rx_stall_pct = 0;
        repeat (25) send_command(random_command());
        tx_gap_max   = 6;
        tx_burst_max = 5;
        rx_stall_pct = 40;
        repeat (60) send_command(random_command());
    endtask

    task automatic test_output_holdoff();
        tx_gap_max     = 0;
        tx_burst_max   = 4;
        hold_requested <= hold_requested + 1;
        repeat (30) send_command(random_command());
    endtask

    // ---------------- output side ----------------

    always @(posedge i_clk) begin : rx_pattern
        bit stall_now;
        stall_now = rx_run_stalled;
        if (hold_served != hold_requested) begin
            hold_served <= hold_requested;
            hold_left   <= HOLD_CYCLES;
            stall_now   = 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            stall_now = 1'b1;
        end else if (rx_run_left == 0) begin
            stall_now = ($urandom_range(99) < rx_stall_pct);
            rx_run_stalled <= stall_now;
            rx_run_left    <= $urandom_range(1, 12);
        end else begin
            rx_run_left <= rx_run_left - 1;
        end
        i_out_stall <= stall_now;
    end

    function automatic void note_mismatch(string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("reply %0d: %s", reply_index, msg);
    endfunction

    always @(posedge i_clk) begin : reply_check
        t_reply want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_replies.size() == 0) begin
                note_mismatch($sformatf("unexpected transfer, pixel %0b done %0b",
                                        o_pixel_value, o_command_done));
            end else begin
                want = pending_replies.pop_front();
                if (o_pixel_value !== want.pixel)
                    note_mismatch($sformatf("pixel_value expected %0b got %0b",
                                            want.pixel, o_pixel_value));
                if (o_command_done !== want.done)
                    note_mismatch($sformatf("command_done expected %0b got %0b",
                                            want.done, o_command_done));
            end
            reply_index++;
        end
    end

    always @(posedge i_clk) begin : watchdog
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("mono_framebuffer_draw_scroll: mismatch");
            $finish;
        end
    end

    initial begin
        foreach (picture[row]) picture[row] = '0;
        tx_gap_max   = 3;
        tx_burst_max = 4;
        rx_stall_pct = 30;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_lines();
        test_rectangles();
        test_shifts();
        test_spare_codes_and_clear();
        test_random_mix();
        test_output_holdoff();

        i_in_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0) begin
            $display("mono_framebuffer_draw_scroll: match");
        end else begin
            $display("mono_framebuffer_draw_scroll: mismatch");
        end
        $finish;
    end

endmodule
